>>> rtl/pwi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwi_pkg;

   localparam int ANGLE_W   = 16;
   localparam int ERR_W     = ANGLE_W + 1;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int COEF_W    = 16;
   localparam int FRAC_W    = 8;
   localparam int WLEN_W    = 7;
   localparam int DRIVE_W   = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // digit-serial multiplier: coefficient consumed one 4-bit digit per cycle
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = COEF_W / DIGIT_W;
   localparam int STEP_W  = $clog2(DIGITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGITS - 1);

   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEGRAL_COEF = 3'd1,
      REG_DERIV_COEF    = 3'd2,
      REG_WINDOW_LENGTH = 3'd3,
      REG_STEP_VALID    = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START_A,
      ST_MUL_A,
      ST_INNER,
      ST_MUL_B,
      ST_OUT
   } ctl_state_type;

endpackage

`default_nettype wire

>>> rtl/pwi_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pwi_req_if;
   import pwi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] measured_angle;
   logic signed [ANGLE_W-1:0] target_angle;

   modport source (output valid, output measured_angle, output target_angle, input ready);
   modport sink   (input valid, input measured_angle, input target_angle, output ready);
endinterface

`default_nettype wire

>>> rtl/pwi_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pwi_rsp_if;
   import pwi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_velocity;
   logic                      ok;

   modport source (output valid, output drive_velocity, output ok, input ready);
   modport sink   (input valid, input drive_velocity, input ok, output ready);
endinterface

`default_nettype wire

>>> rtl/pwi_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pwi_csr_if;
   import pwi_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pid_windowed_integral.sv
`timescale 1ns / 1ps
`default_nettype none

// PID controller with a sliding-window integral.
// req_port carries one word per control step: measured and target angle, Q8.8.
// rsp_port returns one word per step: drive_velocity (Q16.8, saturated) and ok.
// csr_port writes the gain, coefficients, window length and step-valid registers;
// it is always ready and must only be used while no step is in flight.
// Each accepted req word goes through the window update and, if the step is
// valid, the multiplier rounds; they are skipped when step_valid is 0. One step
// is handled at a time, so a new req word is taken only after the last result is loaded.
// The step time comes from the digit-serial multiplier, which runs two rounds
// (integral and derivative terms together, then the gain).
// The result sits in an output register; a new req word is accepted while it
// waits, but the next result holds until rsp_port.ready takes the previous one.
// Reset clears the CSR registers (window length goes to 16), window count, sum,
// pointer, previous error; the store is not cleared: only held entries are read.

module pid_windowed_integral #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pwi_req_if.sink    req_port,
   pwi_rsp_if.source  rsp_port,
   pwi_csr_if.sink    csr_port
);
   import pwi_pkg::*;

   localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W     = ERR_W + CNT_W;
   localparam int IP_PROD_W = SUM_W + COEF_W;
   localparam int IPART_W   = IP_PROD_W - FRAC_W;
   localparam int DP_PROD_W = DIFF_W + COEF_W;
   localparam int DPART_W   = DP_PROD_W - FRAC_W;
   localparam int INNER_W   = SUM_W + 10;
   localparam int KP_PROD_W = INNER_W + COEF_W;
   localparam int DFULL_W   = KP_PROD_W - FRAC_W;

   ctl_state_type state_ff, state_in;

   logic signed [COEF_W-1:0]  prop_gain_ff, integral_coef_ff, deriv_coef_ff;
   logic        [WLEN_W-1:0]  window_length_ff;
   logic                      step_valid_ff;

   logic signed [ERR_W-1:0]   err_ff, err_in, prev_err_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SUM_W-1:0]   window_sum;
   logic signed [IP_PROD_W-1:0] ip_prod;
   logic signed [DP_PROD_W-1:0] dp_prod;
   logic signed [KP_PROD_W-1:0] kp_prod;
   logic signed [IPART_W-1:0] ipart;
   logic signed [DPART_W-1:0] dpart;
   logic signed [INNER_W-1:0] inner;
   logic signed [DFULL_W-1:0] drive_full;
   logic signed [DRIVE_W-1:0] drive_sat;
   logic [DFULL_W-DRIVE_W:0]  drive_hi;

   logic                      rsp_valid_ff, ok_ff;
   logic signed [DRIVE_W-1:0] drive_ff;

   logic req_accept, win_update, mul_a_start, mul_b_start, out_load;
   logic ip_done, dp_done, kp_done;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   assign err_in = ERR_W'(req_port.target_angle) - ERR_W'(req_port.measured_angle);
   assign diff   = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);

   pwi_window #(.WINDOW_MAX(WINDOW_MAX)) u_window (
      .clock         (clock),
      .reset         (reset),
      .update        (win_update),
      .err           (err_ff),
      .window_length (window_length_ff),
      .window_sum    (window_sum)
   );

   pwi_digit_mul #(.MCAND_W(SUM_W)) u_mul_int (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_a_start),
      .coef    (integral_coef_ff),
      .mcand   (window_sum),
      .product (ip_prod),
      .done    (ip_done)
   );

   pwi_digit_mul #(.MCAND_W(DIFF_W)) u_mul_der (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_a_start),
      .coef    (deriv_coef_ff),
      .mcand   (diff),
      .product (dp_prod),
      .done    (dp_done)
   );

   // floor(x / 256) is an arithmetic drop of the fraction bits
   assign ipart = ip_prod[IP_PROD_W-1:FRAC_W];
   assign dpart = dp_prod[DP_PROD_W-1:FRAC_W];
   assign inner = INNER_W'(err_ff) + INNER_W'(ipart) + INNER_W'(dpart);

   pwi_digit_mul #(.MCAND_W(INNER_W)) u_mul_kp (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_b_start),
      .coef    (prop_gain_ff),
      .mcand   (inner),
      .product (kp_prod),
      .done    (kp_done)
   );

   assign drive_full = kp_prod[KP_PROD_W-1:FRAC_W];
   assign drive_hi   = drive_full[DFULL_W-1:DRIVE_W-1];

   always_comb begin
      if (drive_hi == '0 || drive_hi == '1) begin
         drive_sat = drive_full[DRIVE_W-1:0];
      end else if (drive_full[DFULL_W-1]) begin
         drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in    = state_ff;
      win_update  = 1'b0;
      mul_a_start = 1'b0;
      mul_b_start = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            win_update = 1'b1;
            state_in   = step_valid_ff ? ST_START_A : ST_OUT;
         end
         ST_START_A: begin
            mul_a_start = 1'b1;
            state_in    = ST_MUL_A;
         end
         ST_MUL_A: begin
            if (ip_done && dp_done) begin
               state_in = ST_INNER;
            end
         end
         ST_INNER: begin
            mul_b_start = 1'b1;
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            if (kp_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_coef_ff <= '0;
         deriv_coef_ff    <= '0;
         window_length_ff <= WLEN_RESET;
         step_valid_ff    <= 1'b0;
      end else if (csr_port.valid) begin
         unique case (csr_reg_type'(csr_port.index))
            REG_PROP_GAIN:     prop_gain_ff     <= COEF_W'(csr_port.data);
            REG_INTEGRAL_COEF: integral_coef_ff <= COEF_W'(csr_port.data);
            REG_DERIV_COEF:    deriv_coef_ff    <= COEF_W'(csr_port.data);
            REG_WINDOW_LENGTH: window_length_ff <= csr_port.data[WLEN_W-1:0];
            REG_STEP_VALID:    step_valid_ff    <= csr_port.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (step_valid_ff) begin
               prev_err_ff <= err_ff;
            end
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         err_ff <= err_in;
      end
      if (out_load) begin
         drive_ff <= step_valid_ff ? drive_sat : '0;
         ok_ff    <= step_valid_ff;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.drive_velocity = drive_ff;
   assign rsp_port.ok             = ok_ff;

endmodule

`default_nettype wire

>>> rtl/pwi_digit_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pwi_digit_mul #(
   parameter int  MCAND_W = 24,
   localparam int PROD_W  = MCAND_W + pwi_pkg::COEF_W
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [pwi_pkg::COEF_W-1:0]   coef,
   input  wire logic signed [MCAND_W-1:0]           mcand,
   output logic signed [PROD_W-1:0]                 product,
   output logic                                     done
);
   import pwi_pkg::*;

   logic signed [PROD_W-1:0]        acc_ff, acc_in;
   logic        [COEF_W-1:0]        coef_ff, coef_in;
   logic signed [MCAND_W-1:0]       mcand_ff;
   logic        [STEP_W-1:0]        step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic        [DIGIT_W-1:0]       digit;
   logic signed [DIGIT_W:0]         digit_s;
   logic signed [MCAND_W+DIGIT_W:0] pp;

   // MSB digit first: it carries the sign, the rest are unsigned
   assign digit   = coef_ff[COEF_W-1 -: DIGIT_W];
   assign digit_s = (step_ff == '0) ? $signed({digit[DIGIT_W-1], digit})
                                    : $signed({1'b0, digit});
   assign pp      = digit_s * mcand_ff;

   assign done    = busy_ff && (step_ff == LAST_STEP);
   assign product = acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      coef_in = coef_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         coef_in = coef;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = (acc_ff <<< DIGIT_W) + PROD_W'(pp);
         coef_in = coef_ff << DIGIT_W;
         step_in = step_ff + 1'b1;
         busy_in = (step_ff != LAST_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      coef_ff <= coef_in;
      if (start) begin
         mcand_ff <= mcand;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pwi_window.sv
`timescale 1ns / 1ps
`default_nettype none

module pwi_window #(
   parameter int  WINDOW_MAX = 64,
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1),
   localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int SUM_W      = pwi_pkg::ERR_W + CNT_W
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               update,
   input  wire logic signed [pwi_pkg::ERR_W-1:0]   err,
   input  wire logic        [pwi_pkg::WLEN_W-1:0]  window_length,
   output logic signed [SUM_W-1:0]                 window_sum
);
   import pwi_pkg::*;

   logic signed [ERR_W-1:0] mem [WINDOW_MAX];
   logic signed [ERR_W-1:0] rd_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        oldest_ff, oldest_in;
   logic [CNT_W-1:0]        len;
   logic [CNT_W:0]          slot_sum, slot_wide;
   logic [PTR_W-1:0]        slot;
   logic                    full, drop, push;

   always_comb begin
      if (int'(window_length) > WINDOW_MAX) begin
         len = CNT_W'(WINDOW_MAX);
      end else begin
         len = CNT_W'(window_length);
      end
   end

   assign full = (count_ff >= len);
   assign drop = full && (count_ff != '0);
   // zero length with an empty window: the new word is discarded at once
   assign push = !(full && (count_ff == '0));

   // drop-then-push lands on oldest + count either way
   assign slot_sum = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(count_ff);
   assign slot_wide = (slot_sum >= (CNT_W+1)'(WINDOW_MAX))
                      ? slot_sum - (CNT_W+1)'(WINDOW_MAX) : slot_sum;
   assign slot = slot_wide[PTR_W-1:0];

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      oldest_in = oldest_ff;
      if (update) begin
         sum_in = sum_ff - (drop ? SUM_W'(rd_ff) : '0) + (push ? SUM_W'(err) : '0);
         if (drop) begin
            oldest_in = (oldest_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : oldest_ff + 1'b1;
         end
         count_in = count_ff - CNT_W'(drop) + CNT_W'(push);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
      end
   end

   // oldest entry is read continuously; it has settled long before an update
   always_ff @(posedge clock) begin
      if (update && push) begin
         mem[slot] <= err;
      end
      rd_ff <= mem[oldest_ff];
   end

   assign window_sum = sum_ff;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pwi_pkg::*;

   localparam int WINDOW_DEPTH = 64;
   localparam int PHASES       = 13;
   localparam int PHASE_WORDS  = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam longint DRIVE_MAX = (longint'(1) << (DRIVE_W - 1)) - 1;
   localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

   // idle profiles: none, sender idle, receiver stall, both
   localparam int MODES = 4;
   localparam int SEND_IDLE_PCT [MODES] = '{0, 85, 0, 8};
   localparam int RECV_STALL_PCT[MODES] = '{0, 0, 85, 8};

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_velocity;
      logic                      ok;
   } drive_word_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      csr_reg_type               csr_idx;
      logic [CSR_DAT_W-1:0]      value;
      logic signed [ANGLE_W-1:0] meas;
      logic signed [ANGLE_W-1:0] targ;
      bit                        given;
      drive_word_type            want;
   } row_type;

   logic clock;
   logic reset;

   pwi_req_if req_if();
   pwi_rsp_if rsp_if();
   pwi_csr_if csr_if();

   pid_windowed_integral #(
      .WINDOW_MAX(WINDOW_DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_port(csr_if)
   );

   // register mirror
   logic signed [COEF_W-1:0] cfg_prop   = '0;
   logic signed [COEF_W-1:0] cfg_integ  = '0;
   logic signed [COEF_W-1:0] cfg_deriv  = '0;
   logic [WLEN_W-1:0]        cfg_wlen   = WLEN_RESET;
   logic                     cfg_step_on = 1'b0;

   // controller state mirror
   logic signed [ERR_W-1:0] err_hist[WINDOW_DEPTH];
   longint                  hist_sum   = 0;
   int                      hist_count = 0;
   int                      hist_head  = 0;
   logic signed [ERR_W-1:0] last_err   = '0;

   drive_word_type drive_queue[$];
   int             errors    = 0;
   int             send_pct  = 0;
   int             stall_pct = 0;
   bit             holding   = 1'b0;
   event           hold_off;
   row_type        plan[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic drive_word_type predict_drive(input logic signed [ANGLE_W-1:0] meas,
                                                    input logic signed [ANGLE_W-1:0] targ);
      longint         e;
      longint         ipart;
      longint         dpart;
      longint         inner;
      longint         drive;
      int             span;
      int             slot;
      bit             push;
      drive_word_type w;
      e     = longint'(targ) - longint'(meas);
      span  = (cfg_wlen > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_wlen);
      push  = 1'b1;
      // full window: oldest entry leaves before the new one lands
      if (hist_count >= span) begin
         if (hist_count > 0) begin
            hist_sum   -= err_hist[hist_head];
            hist_head   = (hist_head + 1) % WINDOW_DEPTH;
            hist_count -= 1;
         end else begin
            push = 1'b0;
         end
      end
      if (push) begin
         slot           = (hist_head + hist_count) % WINDOW_DEPTH;
         err_hist[slot] = ERR_W'(e);
         hist_sum      += e;
         hist_count    += 1;
      end
      w = '0;
      if (cfg_step_on) begin
         ipart = (longint'(cfg_integ) * hist_sum) >>> FRAC_W;
         dpart = (longint'(cfg_deriv) * (e - longint'(last_err))) >>> FRAC_W;
         inner = e + ipart + dpart;
         drive = (longint'(cfg_prop) * inner) >>> FRAC_W;
         if (drive > DRIVE_MAX) drive = DRIVE_MAX;
         if (drive < DRIVE_MIN) drive = DRIVE_MIN;
         w.drive_velocity = DRIVE_W'(drive);
         w.ok             = 1'b1;
         last_err         = ERR_W'(e);
      end
      return w;
   endfunction

   function automatic row_type csr_row(input csr_reg_type idx,
                                       input logic [CSR_DAT_W-1:0] value);
      row_type r;
      r         = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.value   = value;
      return r;
   endfunction

   function automatic row_type sample_row(input logic signed [ANGLE_W-1:0] meas,
                                          input logic signed [ANGLE_W-1:0] targ);
      row_type r;
      r      = '0;
      r.kind = ROW_SAMPLE;
      r.meas = meas;
      r.targ = targ;
      return r;
   endfunction

   function automatic row_type known_row(input logic signed [ANGLE_W-1:0] meas,
                                         input logic signed [ANGLE_W-1:0] targ,
                                         input logic signed [DRIVE_W-1:0] drive,
                                         input logic ok);
      row_type r;
      r                     = sample_row(meas, targ);
      r.given               = 1'b1;
      r.want.drive_velocity = drive;
      r.want.ok             = ok;
      return r;
   endfunction

   function automatic void add_row(input row_type r);
      plan = {plan, r};
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_gain();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4, 5: return 16'($urandom_range(1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_wlen();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd64;
         3: return 16'd127;
         4: return 16'($urandom_range(127, 65));
         default: return 16'($urandom_range(63, 2));
      endcase
   endfunction

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom_range(63)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [ANGLE_W-1:0] meas,
                              input logic signed [ANGLE_W-1:0] targ,
                              input bit given, input drive_word_type want);
      drive_word_type predicted;
      while ($urandom_range(99) < send_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.measured_angle <= meas;
      req_if.target_angle   <= targ;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_drive(meas, targ);
      drive_queue = {drive_queue, (given ? want : predicted)};
   endtask

   // leaves valid high; the caller lowers it in the step of the last write
   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_PROP_GAIN:     cfg_prop    = value;
         REG_INTEGRAL_COEF: cfg_integ   = value;
         REG_DERIV_COEF:    cfg_deriv   = value;
         REG_WINDOW_LENGTH: cfg_wlen    = value[WLEN_W-1:0];
         REG_STEP_VALID:    cfg_step_on = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      csr_if.valid <= 1'b0;
      do @(posedge clock); while (drive_queue.size() != 0);
   endtask

   task automatic apply_settings(input int mode);
      wait_drained();
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEGRAL_COEF, pick_gain());
      write_reg(REG_DERIV_COEF, pick_gain());
      write_reg(REG_WINDOW_LENGTH, pick_wlen());
      write_reg(REG_STEP_VALID, 16'($urandom_range(4) != 0));
      csr_if.valid <= 1'b0;
      send_pct  = SEND_IDLE_PCT[mode];
      stall_pct = RECV_STALL_PCT[mode];
   endtask

   // long receiver hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         @(hold_off);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || holding)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (drive_queue.size() == 0) begin
            $error("unexpected word: drive_velocity %0d ok %0b",
                   rsp_if.drive_velocity, rsp_if.ok);
            errors++;
         end else begin
            want = drive_queue[0];
            drive_queue.delete(0);
            if (rsp_if.drive_velocity !== want.drive_velocity) begin
               $error("drive_velocity: expected %0d, actual %0d",
                      want.drive_velocity, rsp_if.drive_velocity);
               errors++;
            end
            if (rsp_if.ok !== want.ok) begin
               $error("ok: expected %0b, actual %0b", want.ok, rsp_if.ok);
               errors++;
            end
         end
      end
   end

   initial begin
      logic signed [ANGLE_W-1:0] meas;
      logic signed [ANGLE_W-1:0] targ;
      bit                        in_csr;

      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.measured_angle = '0;
      req_if.target_angle   = '0;
      csr_if.valid          = 1'b0;
      csr_if.index          = REG_PROP_GAIN;
      csr_if.data           = '0;

      // zero-length window from reset keeps the sum at 0 for the known rows
      add_row(csr_row(REG_WINDOW_LENGTH, 16'd0));
      add_row(known_row(16'sd0, 16'sd0, DRIVE_W'(0), 1'b0));
      add_row(known_row(16'sh8000, 16'sh7FFF, DRIVE_W'(0), 1'b0));
      add_row(known_row(16'sh7FFF, 16'sh8000, DRIVE_W'(0), 1'b0));
      add_row(csr_row(REG_PROP_GAIN, 16'h7FFF));
      add_row(csr_row(REG_INTEGRAL_COEF, 16'h7FFF));
      add_row(csr_row(REG_DERIV_COEF, 16'h7FFF));
      add_row(csr_row(REG_STEP_VALID, 16'd1));
      add_row(known_row(16'sh8000, 16'sh7FFF, DRIVE_W'(8388607), 1'b1));
      add_row(known_row(16'sh7FFF, 16'sh8000, DRIVE_W'(-8388608), 1'b1));
      add_row(csr_row(REG_PROP_GAIN, 16'h8000));
      add_row(known_row(16'sh8000, 16'sh7FFF, DRIVE_W'(-8388608), 1'b1));
      add_row(known_row(16'sh7FFF, 16'sh8000, DRIVE_W'(8388607), 1'b1));
      add_row(csr_row(REG_PROP_GAIN, 16'h0000));
      add_row(known_row(16'sd1234, -16'sd4321, DRIVE_W'(0), 1'b1));
      add_row(csr_row(REG_PROP_GAIN, 16'h0100));
      add_row(csr_row(REG_DERIV_COEF, 16'h0000));
      add_row(known_row(16'sd100, 16'sd356, DRIVE_W'(256), 1'b1));
      add_row(known_row(16'sd0, -16'sd1, DRIVE_W'(-1), 1'b1));
      add_row(csr_row(REG_PROP_GAIN, 16'h0001));
      add_row(known_row(16'sd0, -16'sd1, DRIVE_W'(-1), 1'b1));
      add_row(known_row(16'sd0, 16'sd255, DRIVE_W'(0), 1'b1));
      add_row(csr_row(REG_WINDOW_LENGTH, 16'd3));
      add_row(csr_row(REG_PROP_GAIN, 16'd300));
      add_row(csr_row(REG_INTEGRAL_COEF, 16'd128));
      add_row(csr_row(REG_DERIV_COEF, -16'sd300));
      add_row(sample_row(16'sd10, -16'sd20));
      add_row(sample_row(16'sd0, 16'sd500));
      add_row(sample_row(-16'sd300, 16'sd300));
      add_row(sample_row(16'sh7FFF, 16'sh8000));
      // shorter window than held entries: each step drops one and pushes one, so count holds
      add_row(csr_row(REG_WINDOW_LENGTH, 16'd1));
      add_row(sample_row(16'sd5, 16'sd5));
      add_row(sample_row(16'sd1, 16'sd2));
      add_row(sample_row(-16'sd7, 16'sd9));
      add_row(csr_row(REG_WINDOW_LENGTH, 16'd127));
      add_row(sample_row(16'sh8000, 16'sh7FFF));
      add_row(sample_row(16'sd77, -16'sd1000));
      add_row(csr_row(REG_STEP_VALID, 16'd0));
      add_row(known_row(16'sd3, 16'sd4, DRIVE_W'(0), 1'b0));
      add_row(known_row(-16'sd900, 16'sd450, DRIVE_W'(0), 1'b0));
      add_row(csr_row(REG_STEP_VALID, 16'd1));
      add_row(sample_row(16'sd12, 16'sd40));
      add_row(sample_row(16'sd0, -16'sd64));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      in_csr = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!in_csr) wait_drained();
            write_reg(plan[i].csr_idx, plan[i].value);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_if.valid <= 1'b0;
            in_csr = 1'b0;
            send_sample(plan[i].meas, plan[i].targ, plan[i].given, plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(phase % MODES);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase == 0 && n == 40) -> hold_off;
            if (phase == 1 && n == 75) wait_drained();
            meas = pick_angle();
            if ($urandom_range(2) == 0)
               targ = meas + 16'($urandom_range(255)) - 16'd128;
            else
               targ = pick_angle();
            send_sample(meas, targ, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && drive_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
